### hw/rtl/handle_table_free_list_macros.svh
// Assertion macros used by the checker file htfl_checker.sv.
`ifndef HANDLE_TABLE_FREE_LIST_MACROS_SVH
`define HANDLE_TABLE_FREE_LIST_MACROS_SVH

// Same-cycle implication.
`define HTFL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/htfl_pkg.sv
package htfl_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_UPDATE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_REL_LINK,
    ST_SCAN,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/handle_table_free_list.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o   | action_i, slot_index_i, address_i
// out     | output    | out_valid_o / out_ready_i | result_slot_o, error_o,
//         |           |                           | free_count_o, used_size_o
//
// One item at a time. Append, clear, unknown actions and errors caught at decode
// go from decode straight to done; allocate from the free list, update and double
// release pass through check, and release then links the slot onto the free list.
// A lookup runs scan then compare per slot, reusing the one address comparator.
// The slot and link memories each have one read port and one write port.
// Reset clears the sequencer, free-list head and tail and both counts; no memory sweep.
// in_ready_o is high only when idle; a result holds until out_ready_i takes it.
module handle_table_free_list #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [htfl_pkg::ACTION_W-1:0]  action_i,
  input  logic [htfl_pkg::SLOT_W-1:0]    slot_index_i,
  input  logic [htfl_pkg::ADDR_W-1:0]    address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [htfl_pkg::SLOT_W-1:0]    result_slot_o,
  output logic                           error_o,
  output logic [htfl_pkg::COUNT_W-1:0]   free_count_o,
  output logic [htfl_pkg::COUNT_W-1:0]   used_size_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned SW = htfl_pkg::SLOT_W;
  localparam int unsigned CW = htfl_pkg::COUNT_W;
  localparam int unsigned AW = htfl_pkg::ADDR_W;
  localparam int unsigned XW = (LW > SW) ? LW : SW;
  localparam logic [LW-1:0] NULL_LINK = LW'(TABLE_ENTRIES);

  htfl_pkg::state_e state_q, state_d;

  logic [htfl_pkg::ACTION_W-1:0] act_q;
  logic [SW-1:0]                 idx_q;
  logic [AW-1:0]                 addr_q;

  logic [IW-1:0] s_q, s_d;
  logic [IW-1:0] i_q, i_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] tail_q, tail_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [LW-1:0] total_q, total_d;
  logic [IW-1:0] res_slot_q, res_slot_d;
  logic          err_q, err_d;

  logic [AW-1:0] addr_mem [TABLE_ENTRIES];
  logic          free_mem [TABLE_ENTRIES];
  logic [LW-1:0] next_mem [TABLE_ENTRIES];
  logic [LW-1:0] prev_mem [TABLE_ENTRIES];

  logic [IW-1:0] rd_addr;
  logic [AW-1:0] addr_rd;
  logic          free_rd;
  logic [LW-1:0] next_rd;
  logic [LW-1:0] prev_rd;

  logic          addr_we, free_we, next_we, prev_we;
  logic [IW-1:0] addr_wa, free_wa, next_wa, prev_wa;
  logic [AW-1:0] addr_wd;
  logic          free_wd;
  logic [LW-1:0] next_wd, prev_wd;

  logic          in_acc;
  logic          idx_bad;
  logic [IW-1:0] idx_slot;
  logic          head_ok, tail_ok, table_full, scan_last, addr_hit;

  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_bad    = XW'(idx_q) >= XW'(fill_q);
  assign idx_slot   = IW'(idx_q);
  assign head_ok    = head_q != NULL_LINK;
  assign tail_ok    = tail_q != NULL_LINK;
  assign table_full = fill_q == LW'(TABLE_ENTRIES);
  assign scan_last  = ({1'b0, i_q} + LW'(1)) == fill_q;
  assign addr_hit   = addr_rd == addr_q;

  always_comb begin
    if (state_q == htfl_pkg::ST_SCAN) begin
      rd_addr = i_q;
    end else if (act_q == htfl_pkg::ACT_ALLOC) begin
      rd_addr = head_q[IW-1:0];
    end else begin
      rd_addr = idx_slot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[addr_wa] <= addr_wd;
    end
    addr_rd <= addr_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    free_rd <= free_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd <= prev_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htfl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = htfl_pkg::ST_DECODE;
        end
      end
      htfl_pkg::ST_DECODE: begin
        unique case (act_q)
          htfl_pkg::ACT_ALLOC: begin
            state_d = head_ok ? htfl_pkg::ST_CHECK : htfl_pkg::ST_DONE;
          end
          htfl_pkg::ACT_UPDATE, htfl_pkg::ACT_RELEASE: begin
            state_d = idx_bad ? htfl_pkg::ST_DONE : htfl_pkg::ST_CHECK;
          end
          htfl_pkg::ACT_LOOKUP: begin
            state_d = (fill_q == '0) ? htfl_pkg::ST_DONE : htfl_pkg::ST_SCAN;
          end
          default: begin
            state_d = htfl_pkg::ST_DONE;
          end
        endcase
      end
      htfl_pkg::ST_CHECK: begin
        if (act_q == htfl_pkg::ACT_RELEASE && !free_rd) begin
          state_d = htfl_pkg::ST_REL_LINK;
        end else begin
          state_d = htfl_pkg::ST_DONE;
        end
      end
      htfl_pkg::ST_REL_LINK: begin
        state_d = htfl_pkg::ST_DONE;
      end
      htfl_pkg::ST_SCAN: begin
        state_d = htfl_pkg::ST_CMP;
      end
      htfl_pkg::ST_CMP: begin
        state_d = (addr_hit || scan_last) ? htfl_pkg::ST_DONE : htfl_pkg::ST_SCAN;
      end
      htfl_pkg::ST_DONE: begin
        if (out_ready_i) begin
          state_d = htfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = htfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_d        = s_q;
    i_d        = i_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    total_d    = total_q;
    res_slot_d = res_slot_q;
    err_d      = err_q;
    addr_we    = 1'b0;
    addr_wa    = s_q;
    addr_wd    = addr_q;
    free_we    = 1'b0;
    free_wa    = s_q;
    free_wd    = 1'b0;
    next_we    = 1'b0;
    next_wa    = s_q;
    next_wd    = NULL_LINK;
    prev_we    = 1'b0;
    prev_wa    = s_q;
    prev_wd    = NULL_LINK;
    unique case (state_q)
      htfl_pkg::ST_DECODE: begin
        s_d = rd_addr;
        i_d = '0;
        unique case (act_q)
          htfl_pkg::ACT_ALLOC: begin
            if (!head_ok) begin
              if (table_full) begin
                err_d      = 1'b1;
                res_slot_d = '0;
              end else begin
                addr_we    = 1'b1;
                addr_wa    = fill_q[IW-1:0];
                free_we    = 1'b1;
                free_wa    = fill_q[IW-1:0];
                free_wd    = 1'b0;
                fill_d     = fill_q + LW'(1);
                res_slot_d = fill_q[IW-1:0];
                err_d      = 1'b0;
              end
            end
          end
          htfl_pkg::ACT_UPDATE, htfl_pkg::ACT_RELEASE: begin
            if (idx_bad) begin
              err_d      = 1'b1;
              res_slot_d = '0;
            end
          end
          htfl_pkg::ACT_LOOKUP: begin
            if (fill_q == '0) begin
              err_d      = 1'b1;
              res_slot_d = '0;
            end
          end
          htfl_pkg::ACT_CLEAR: begin
            head_d     = NULL_LINK;
            tail_d     = NULL_LINK;
            fill_d     = '0;
            total_d    = '0;
            res_slot_d = '0;
            err_d      = 1'b0;
          end
          default: begin
            err_d      = 1'b1;
            res_slot_d = '0;
          end
        endcase
      end
      htfl_pkg::ST_CHECK: begin
        if (act_q == htfl_pkg::ACT_RELEASE) begin
          if (free_rd) begin
            err_d      = 1'b1;
            res_slot_d = '0;
          end else begin
            addr_we = 1'b1;
            addr_wd = '0;
            free_we = 1'b1;
            free_wd = 1'b1;
            next_we = 1'b1;
            next_wd = NULL_LINK;
            prev_we = 1'b1;
            prev_wd = tail_q;
          end
        end else if (act_q == htfl_pkg::ACT_UPDATE && !free_rd) begin
          addr_we    = 1'b1;
          res_slot_d = s_q;
          err_d      = 1'b0;
        end else begin
          // unlink the slot from the free list
          if (prev_rd != NULL_LINK) begin
            next_we = 1'b1;
            next_wa = prev_rd[IW-1:0];
            next_wd = next_rd;
          end else begin
            head_d = next_rd;
          end
          if (next_rd != NULL_LINK) begin
            prev_we = 1'b1;
            prev_wa = next_rd[IW-1:0];
            prev_wd = prev_rd;
          end else begin
            tail_d = prev_rd;
          end
          free_we = 1'b1;
          free_wd = 1'b0;
          addr_we = 1'b1;
          if (total_q != '0) begin
            total_d = total_q - LW'(1);
          end
          res_slot_d = s_q;
          err_d      = 1'b0;
        end
      end
      htfl_pkg::ST_REL_LINK: begin
        if (tail_ok) begin
          next_we = 1'b1;
          next_wa = tail_q[IW-1:0];
          next_wd = {1'b0, s_q};
        end else begin
          head_d = {1'b0, s_q};
        end
        tail_d     = {1'b0, s_q};
        total_d    = total_q + LW'(1);
        res_slot_d = s_q;
        err_d      = 1'b0;
      end
      htfl_pkg::ST_CMP: begin
        if (addr_hit) begin
          res_slot_d = i_q;
          err_d      = 1'b0;
        end else if (scan_last) begin
          res_slot_d = '0;
          err_d      = 1'b1;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htfl_pkg::ST_IDLE;
      head_q  <= NULL_LINK;
      tail_q  <= NULL_LINK;
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      idx_q  <= slot_index_i;
      addr_q <= address_i;
    end
    s_q        <= s_d;
    i_q        <= i_d;
    res_slot_q <= res_slot_d;
    err_q      <= err_d;
  end

  assign in_ready_o    = state_q == htfl_pkg::ST_IDLE;
  assign out_valid_o   = state_q == htfl_pkg::ST_DONE;
  assign result_slot_o = SW'(res_slot_q);
  assign error_o       = err_q;
  assign free_count_o  = CW'(total_q);
  assign used_size_o   = CW'(fill_q);

endmodule

### hw/rtl/htfl_checker.sv
`include "handle_table_free_list_macros.svh"

module htfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [htfl_pkg::SLOT_W-1:0]   result_slot_o,
  input logic                          error_o,
  input logic [htfl_pkg::COUNT_W-1:0]  free_count_o,
  input logic [htfl_pkg::COUNT_W-1:0]  used_size_o
);

  `HTFL_ASSERT_IMPL(a_err_slot_zero, clk_i, rst_ni, out_valid_o && error_o, result_slot_o == '0, "error item carries a nonzero slot")
  `HTFL_ASSERT_IMPL(a_free_le_used, clk_i, rst_ni, out_valid_o, free_count_o <= used_size_o, "free count exceeds used size")
  `HTFL_ASSERT_IMPL(a_one_item, clk_i, rst_ni, out_valid_o, !in_ready_o, "input ready while a result is pending")
  `HTFL_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after an accepted item")
  `HTFL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_slot_o) && $stable(error_o), "stalled result changed")

endmodule

bind handle_table_free_list htfl_checker u_htfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_slot_o (result_slot_o),
  .error_o       (error_o),
  .free_count_o  (free_count_o),
  .used_size_o   (used_size_o)
);
